>>> hdl/i4rdp_pkg.sv
// Package for the int4 row dot product core: widths, codes, FSM states,
// the control bundle and the weight decode. No dependencies.
`timescale 1ns / 1ps
package i4rdp_pkg;

  localparam int ACT_W    = 16;
  localparam int CODE_W   = 4;
  localparam int SCALE_W  = 16;
  localparam int RES_W    = 32;
  localparam int SHIFT_W  = 5;
  localparam int SUM_W    = 40;
  localparam int SLICE_W  = 20;
  localparam int OPA_W    = SLICE_W + 1;
  localparam int PROD_W   = OPA_W + SCALE_W;
  localparam int SCALED_W = 56;

  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd12;
  localparam logic [RES_W-1:0]   RES_MAX     = 32'h7FFF_FFFF;
  localparam logic [RES_W-1:0]   RES_MIN     = 32'h8000_0000;
  localparam logic [CODE_W-1:0]  CODE_BIAS   = 4'h8;

  typedef enum logic [1:0] {
    OP_WGT,
    OP_LO,
    OP_HI
  } op_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_W,
    S_ADD_W,
    S_MUL_LO,
    S_ADD_LO,
    S_MUL_HI,
    S_ADD_HI,
    S_SHIFT,
    S_SAT
  } state_t;

  typedef struct packed {
    logic    in_ready;
    logic    mul_en;
    op_sel_t op_sel;
    logic    add_w;
    logic    add_lo;
    logic    add_hi;
    logic    shift_en;
    logic    out_load;
  } ctrl_t;

  // code - 8 modulo 16, read as a signed nibble
  function automatic logic signed [CODE_W-1:0] decode_weight(input logic [CODE_W-1:0] code);
    decode_weight = code ^ CODE_BIAS;
  endfunction

endpackage

>>> hdl/i4rdp_if.sv
// Valid/ready channel interfaces for the term input and the result output.
// Depends on i4rdp_pkg.
`timescale 1ns / 1ps
interface i4rdp_in_if
  import i4rdp_pkg::*;
  ();
  logic                      valid;
  logic                      ready;
  logic signed [ACT_W-1:0]   activation;
  logic        [CODE_W-1:0]  weight_code;
  logic signed [SCALE_W-1:0] row_scale;
  logic                      last_term;

  modport source (output valid, activation, weight_code, row_scale, last_term, input ready);
  modport sink   (input valid, activation, weight_code, row_scale, last_term, output ready);
endinterface

interface i4rdp_out_if
  import i4rdp_pkg::*;
  ();
  logic                    valid;
  logic                    ready;
  logic signed [RES_W-1:0] dot_result;
  logic                    saturated;

  modport source (output valid, dot_result, saturated, input ready);
  modport sink   (input valid, dot_result, saturated, output ready);
endinterface

>>> hdl/int4_row_dot_product_scaled_core.sv
// Top level of the int4 row dot product core: term capture, 40-bit sum,
// scale, shift, saturation and output register. Depends on i4rdp_pkg,
// i4rdp_if, i4rdp_mul and i4rdp_ctrl.
//
// Usage:
//   in_ch  : one term per transaction (activation Q4.12, weight nibble,
//            row scale, last flag). Weight decodes as code minus 8.
//   out_ch : one result per row, on the term flagged last: the sum times
//            row_scale, floor-shifted right by result_shift and clipped
//            to signed 32 bits, with saturated set when clipped.
//   cfg_*  : cfg_we writes cfg_wdata into result_shift (reset 12).
// Timing: a term that is not last passes through accept, multiply and add;
//   in_ch.ready is high only while the sequencer is idle. A last term
//   goes on after the add: the 40-bit sum is multiplied by the scale in two
//   20-bit halves on the one shared 21x16 multiplier, then shifted and
//   saturated. The result is valid on out_ch the cycle after it is loaded.
// Reset clears the sum, the sequencer and the output valid flag, and sets
//   result_shift to 12. A stalled receiver holds the result in the output
//   register; the next row runs until its own result is ready to load,
//   and waits there for the register to free.
`timescale 1ns / 1ps
module int4_row_dot_product_scaled_core
  import i4rdp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  i4rdp_in_if.sink           in_ch,
  i4rdp_out_if.source        out_ch,
  input  logic               cfg_we,
  input  logic [SHIFT_W-1:0] cfg_wdata
);

  ctrl_t  ctrl;

  logic                       in_fire;
  logic                       out_free;
  logic [SHIFT_W-1:0]         shift_r;
  logic signed [ACT_W-1:0]    act_r;
  logic [CODE_W-1:0]          code_r;
  logic signed [SCALE_W-1:0]  scale_r;
  logic                       last_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic signed [SUM_W-1:0]    sum_nxt;
  logic signed [SCALED_W-1:0] scaled_r;
  logic signed [SCALED_W-1:0] scaled_nxt;
  logic signed [SCALED_W-1:0] shifted_r;
  logic signed [OPA_W-1:0]    op_a;
  logic signed [SCALE_W-1:0]  op_b;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [CODE_W-1:0]   wgt;
  logic                       sat;
  logic [RES_W-1:0]           res;
  logic                       out_valid_r;
  logic [RES_W-1:0]           out_data_r;
  logic                       out_sat_r;

  i4rdp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .last_r   (last_r),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  assign in_ch.ready = ctrl.in_ready;
  assign in_fire     = in_ch.valid && ctrl.in_ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign wgt         = decode_weight(code_r);

  always_comb begin
    case (ctrl.op_sel)
      OP_LO: begin
        op_a = {1'b0, sum_r[SLICE_W-1:0]};
        op_b = scale_r;
      end
      OP_HI: begin
        op_a = {sum_r[SUM_W-1], sum_r[SUM_W-1:SLICE_W]};
        op_b = scale_r;
      end
      default: begin
        op_a = {{(OPA_W-CODE_W){wgt[CODE_W-1]}}, wgt};
        op_b = act_r;
      end
    endcase
  end

  i4rdp_mul u_mul (
    .clk    (clk),
    .en     (ctrl.mul_en),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod_r)
  );

  assign sum_nxt = sum_r + {{(SUM_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  always_comb begin
    if (ctrl.add_hi) begin
      scaled_nxt = scaled_r + {prod_r[SCALED_W-SLICE_W-1:0], {SLICE_W{1'b0}}};
    end else begin
      scaled_nxt = {{(SCALED_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    end
  end

  assign sat = !((&shifted_r[SCALED_W-1:RES_W-1]) || !(|shifted_r[SCALED_W-1:RES_W-1]));
  assign res = sat ? (shifted_r[SCALED_W-1] ? RES_MIN : RES_MAX) : shifted_r[RES_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= SHIFT_RESET;
    end else if (cfg_we) begin
      shift_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r   <= in_ch.activation;
      code_r  <= in_ch.weight_code;
      scale_r <= in_ch.row_scale;
      last_r  <= in_ch.last_term;
    end
    if (ctrl.add_lo || ctrl.add_hi) begin
      scaled_r <= scaled_nxt;
    end
    if (ctrl.shift_en) begin
      shifted_r <= scaled_r >>> shift_r;
    end
    if (ctrl.out_load) begin
      out_data_r <= res;
      out_sat_r  <= sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (ctrl.out_load) begin
      sum_r <= '0;
    end else if (ctrl.add_w) begin
      sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.dot_result = out_data_r;
  assign out_ch.saturated  = out_sat_r;

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ch.ready)
    else $error("input accepted while a transaction is in flight");

  a_load_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.out_load |=> out_ch.valid)
    else $error("loaded result not presented");

  a_sum_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.out_load |=> (sum_r == '0))
    else $error("running sum not cleared after row result");

  a_sat_clips: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.saturated) |->
      (out_ch.dot_result == RES_MAX || out_ch.dot_result == RES_MIN))
    else $error("saturated flag with unclipped result");
`endif

endmodule

>>> hdl/i4rdp_mul.sv
// Shared signed multiplier with a registered product, used for the term
// products and for both halves of the scale multiply. Depends on i4rdp_pkg.
`timescale 1ns / 1ps
module i4rdp_mul
  import i4rdp_pkg::*;
(
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [OPA_W-1:0]   op_a,
  input  logic signed [SCALE_W-1:0] op_b,
  output logic signed [PROD_W-1:0]  prod_r
);

  logic signed [PROD_W-1:0] prod_nxt;

  assign prod_nxt = PROD_W'(op_a * op_b);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

>>> hdl/i4rdp_ctrl.sv
// Sequencer for the dot product core: walks one transaction through the
// shared multiplier and the adder. Depends on i4rdp_pkg.
`timescale 1ns / 1ps
module i4rdp_ctrl
  import i4rdp_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  input  logic   last_r,
  input  logic   out_free,
  output ctrl_t  ctrl
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_MUL_W;
      S_MUL_W:  state_nxt = S_ADD_W;
      S_ADD_W:  state_nxt = last_r ? S_MUL_LO : S_IDLE;
      S_MUL_LO: state_nxt = S_ADD_LO;
      S_ADD_LO: state_nxt = S_MUL_HI;
      S_MUL_HI: state_nxt = S_ADD_HI;
      S_ADD_HI: state_nxt = S_SHIFT;
      S_SHIFT:  state_nxt = S_SAT;
      S_SAT:    if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    ctrl.op_sel = OP_WGT;
    unique case (state_r)
      S_IDLE:   ctrl.in_ready = 1'b1;
      S_MUL_W:  ctrl.mul_en = 1'b1;
      S_ADD_W:  ctrl.add_w = 1'b1;
      S_MUL_LO: begin
        ctrl.mul_en = 1'b1;
        ctrl.op_sel = OP_LO;
      end
      S_ADD_LO: ctrl.add_lo = 1'b1;
      S_MUL_HI: begin
        ctrl.mul_en = 1'b1;
        ctrl.op_sel = OP_HI;
      end
      S_ADD_HI: ctrl.add_hi = 1'b1;
      S_SHIFT:  ctrl.shift_en = 1'b1;
      S_SAT:    ctrl.out_load = out_free;
      default:  ctrl = '0;
    endcase
  end

endmodule
